### src/cfd_pkg.sv
// Package for the CPPM frame decoder: sequencer states, shared-unit opcodes,
// control word and register constants. No dependencies.
`timescale 1ns / 1ps

package cfd_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned PULSE_W  = 16;
  localparam int unsigned ERR_W    = 16;
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [PULSE_W-1:0] RESET_WIDTH     = 16'd1500;
  localparam logic [PULSE_W-1:0] MIN_PULSE_RST   = 16'd900;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST   = 16'd2100;
  localparam logic [PULSE_W-1:0] SYNC_PULSE_RST  = 16'd2700;

  // register index = paddr[3:2]
  localparam logic [1:0] REG_MIN_PULSE  = 2'd0;
  localparam logic [1:0] REG_MAX_PULSE  = 2'd1;
  localparam logic [1:0] REG_SYNC_PULSE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_CMIN,
    ST_CMAX,
    ST_CSYNC,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    ALU_DIFF,   // edge_time - prev_edge_time
    ALU_MIN,    // width < min_pulse
    ALU_MAX,    // max_pulse < width
    ALU_SYNC    // width < sync_pulse
  } alu_sel_t;

  typedef struct packed {
    logic     in_ready;
    logic     out_valid;
    alu_sel_t alu_sel;
    logic     ld_width;
    logic     ld_min;
    logic     ld_max;
    logic     ld_sync;
    logic     commit;
  } ctrl_t;

endpackage

### src/cppm_frame_decoder_unit.sv
// CPPM frame decoder: takes one rising-edge timestamp per input word, measures
// the gap since the previous edge (the first from time 0), checks it against
// the min/max/sync registers, fills channel slots, and on a sync gap streams
// the held frame out as NUM_CHANNELS words, the last flagged. Out-of-range
// gaps bump a wrapping error count and drop the frame. An edge passes through
// the difference, the three limit compares and the commit before the next one
// can be taken; a sync edge that releases a frame also waits, through any output
// stall, until its last word is taken. The steps follow from the single 32-bit
// subtract/compare unit, used once per cycle for the difference and each of the
// three limit compares. Depends on cfd_pkg, cfd_cfg_regs, cfd_alu, cfd_ctrl.
`timescale 1ns / 1ps

module cppm_frame_decoder_unit #(
  parameter int unsigned NUM_CHANNELS = 6
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [cfd_pkg::TIME_W-1:0]            in_edge_time,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1)-1:0] out_channel_index,
  output logic [cfd_pkg::PULSE_W-1:0]           out_channel_width,
  output logic                                  out_frame_last,
  output logic [cfd_pkg::ERR_W-1:0]             out_error_total,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [cfd_pkg::PADDR_W-1:0]           paddr,
  input  logic [cfd_pkg::PDATA_W-1:0]           pwdata,
  output logic [cfd_pkg::PDATA_W-1:0]           prdata,
  output logic                                  pready
);
  import cfd_pkg::*;

  localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_CHANNELS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);
  localparam logic [CNT_W-1:0] NUM_CNT  = CNT_W'(NUM_CHANNELS);

  logic [PULSE_W-1:0] min_pulse, max_pulse, sync_pulse;
  ctrl_t              ctrl;
  logic [TIME_W-1:0]  alu_diff;
  logic               alu_borrow;

  logic [TIME_W-1:0]  now_r, prev_r, width_r;
  logic               lt_min_r, gt_max_r, lt_sync_r;
  logic               poisoned_r;
  logic [CNT_W-1:0]   slot_cnt_r;
  logic [IDX_W-1:0]   emit_idx_r;
  logic [ERR_W-1:0]   err_cnt_r;
  logic [PULSE_W-1:0] slots_r [NUM_CHANNELS];

  logic pulse_err, emit_go, emit_last, in_fire, out_fire;

  cfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .min_pulse (min_pulse),
    .max_pulse (max_pulse),
    .sync_pulse(sync_pulse)
  );

  cfd_alu u_alu (
    .sel       (ctrl.alu_sel),
    .now_time  (now_r),
    .prev_time (prev_r),
    .width     (width_r),
    .min_pulse (min_pulse),
    .max_pulse (max_pulse),
    .sync_pulse(sync_pulse),
    .diff      (alu_diff),
    .borrow    (alu_borrow)
  );

  cfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_ready(out_ready),
    .emit_go  (emit_go),
    .emit_last(emit_last),
    .ctrl     (ctrl)
  );

  assign in_ready  = ctrl.in_ready;
  assign out_valid = ctrl.out_valid;
  assign in_fire   = in_valid & in_ready;
  assign out_fire  = out_valid & out_ready;

  // out of range: below min, or above max but short of sync
  assign pulse_err = lt_min_r | (gt_max_r & lt_sync_r);
  assign emit_go   = ~lt_sync_r & ~(poisoned_r | pulse_err);
  assign emit_last = (emit_idx_r == LAST_IDX);

  always_ff @(posedge clk) begin
    if (in_fire) now_r <= in_edge_time;
    if (ctrl.ld_width) width_r <= alu_diff;
    if (ctrl.ld_min) lt_min_r <= alu_borrow;
    if (ctrl.ld_max) gt_max_r <= alu_borrow;
    if (ctrl.ld_sync) lt_sync_r <= alu_borrow;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r     <= '0;
      poisoned_r <= 1'b0;
      slot_cnt_r <= '0;
      emit_idx_r <= '0;
      err_cnt_r  <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) slots_r[i] <= RESET_WIDTH;
    end else begin
      if (ctrl.ld_width) prev_r <= now_r;
      if (ctrl.commit) begin
        if (pulse_err) err_cnt_r <= err_cnt_r + 1'b1;
        emit_idx_r <= '0;
        if (!lt_sync_r) begin
          slot_cnt_r <= '0;
          poisoned_r <= 1'b0;
        end else begin
          if (pulse_err) poisoned_r <= 1'b1;
          if (!poisoned_r && !pulse_err && slot_cnt_r < NUM_CNT) begin
            slots_r[slot_cnt_r[IDX_W-1:0]] <= width_r[PULSE_W-1:0];
            slot_cnt_r <= slot_cnt_r + 1'b1;
          end
        end
      end
      if (out_fire && !emit_last) emit_idx_r <= emit_idx_r + 1'b1;
    end
  end

  assign out_channel_index = emit_idx_r;
  assign out_channel_width = slots_r[emit_idx_r];
  assign out_frame_last    = emit_last;
  assign out_error_total   = err_cnt_r;

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while a frame is streaming");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (emit_idx_r <= LAST_IDX))
    else $error("channel index past last slot");

  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_frame_last) |=> in_ready)
    else $error("not ready after last word of frame");

  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slot_cnt_r <= NUM_CNT)
    else $error("slot counter overran channel count");

endmodule

### src/cfd_cfg_regs.sv
// APB-style configuration registers: min, max and sync pulse limits.
// Depends on cfd_pkg.
`timescale 1ns / 1ps

module cfd_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cfd_pkg::PADDR_W-1:0] paddr,
  input  logic [cfd_pkg::PDATA_W-1:0] pwdata,
  output logic [cfd_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output logic [cfd_pkg::PULSE_W-1:0] min_pulse,
  output logic [cfd_pkg::PULSE_W-1:0] max_pulse,
  output logic [cfd_pkg::PULSE_W-1:0] sync_pulse
);
  import cfd_pkg::*;

  logic [PULSE_W-1:0] min_r, max_r, sync_r;
  logic               wr_en;
  logic [1:0]         reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= MIN_PULSE_RST;
      max_r  <= MAX_PULSE_RST;
      sync_r <= SYNC_PULSE_RST;
    end else if (wr_en) begin
      if (reg_idx == REG_MIN_PULSE)  min_r  <= pwdata[PULSE_W-1:0];
      if (reg_idx == REG_MAX_PULSE)  max_r  <= pwdata[PULSE_W-1:0];
      if (reg_idx == REG_SYNC_PULSE) sync_r <= pwdata[PULSE_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MIN_PULSE:  prdata = {{(PDATA_W-PULSE_W){1'b0}}, min_r};
      REG_MAX_PULSE:  prdata = {{(PDATA_W-PULSE_W){1'b0}}, max_r};
      REG_SYNC_PULSE: prdata = {{(PDATA_W-PULSE_W){1'b0}}, sync_r};
      default:        prdata = '0;
    endcase
  end

  assign min_pulse  = min_r;
  assign max_pulse  = max_r;
  assign sync_pulse = sync_r;

endmodule

### src/cfd_alu.sv
// Shared 32-bit subtract/compare unit: one subtraction per cycle, the
// borrow gives the a < b compare. Depends on cfd_pkg.
`timescale 1ns / 1ps

module cfd_alu (
  input  cfd_pkg::alu_sel_t           sel,
  input  logic [cfd_pkg::TIME_W-1:0]  now_time,
  input  logic [cfd_pkg::TIME_W-1:0]  prev_time,
  input  logic [cfd_pkg::TIME_W-1:0]  width,
  input  logic [cfd_pkg::PULSE_W-1:0] min_pulse,
  input  logic [cfd_pkg::PULSE_W-1:0] max_pulse,
  input  logic [cfd_pkg::PULSE_W-1:0] sync_pulse,
  output logic [cfd_pkg::TIME_W-1:0]  diff,
  output logic                        borrow
);
  import cfd_pkg::*;

  logic [TIME_W-1:0] op_a, op_b;
  logic [TIME_W:0]   res;

  always_comb begin
    unique case (sel)
      ALU_DIFF: begin
        op_a = now_time;
        op_b = prev_time;
      end
      ALU_MIN: begin
        op_a = width;
        op_b = {{(TIME_W-PULSE_W){1'b0}}, min_pulse};
      end
      ALU_MAX: begin
        op_a = {{(TIME_W-PULSE_W){1'b0}}, max_pulse};
        op_b = width;
      end
      ALU_SYNC: begin
        op_a = width;
        op_b = {{(TIME_W-PULSE_W){1'b0}}, sync_pulse};
      end
    endcase
  end

  assign res    = {1'b0, op_a} - {1'b0, op_b};
  assign diff   = res[TIME_W-1:0];
  assign borrow = res[TIME_W];

endmodule

### src/cfd_ctrl.sv
// Sequencer for the decoder: steps the shared unit through difference and
// the three limit compares, commits, then streams out the frame when a sync
// gap releases one. Depends on cfd_pkg.
`timescale 1ns / 1ps

module cfd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             out_ready,
  input  logic             emit_go,
  input  logic             emit_last,
  output cfd_pkg::ctrl_t   ctrl
);
  import cfd_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_DIFF;
      ST_DIFF:   state_nxt = ST_CMIN;
      ST_CMIN:   state_nxt = ST_CMAX;
      ST_CMAX:   state_nxt = ST_CSYNC;
      ST_CSYNC:  state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = emit_go ? ST_EMIT : ST_IDLE;
      ST_EMIT:   if (out_ready && emit_last) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '{in_ready: 1'b0, out_valid: 1'b0, alu_sel: ALU_DIFF, ld_width: 1'b0,
             ld_min: 1'b0, ld_max: 1'b0, ld_sync: 1'b0, commit: 1'b0};
    unique case (state_r)
      ST_IDLE:   ctrl.in_ready = 1'b1;
      ST_DIFF: begin
        ctrl.alu_sel  = ALU_DIFF;
        ctrl.ld_width = 1'b1;
      end
      ST_CMIN: begin
        ctrl.alu_sel = ALU_MIN;
        ctrl.ld_min  = 1'b1;
      end
      ST_CMAX: begin
        ctrl.alu_sel = ALU_MAX;
        ctrl.ld_max  = 1'b1;
      end
      ST_CSYNC: begin
        ctrl.alu_sel = ALU_SYNC;
        ctrl.ld_sync = 1'b1;
      end
      ST_UPDATE: ctrl.commit    = 1'b1;
      ST_EMIT:   ctrl.out_valid = 1'b1;
      default:   ctrl.in_ready  = 1'b0;
    endcase
  end

endmodule
